@@ design/slu_pkg.sv @@
// Shared types, codes and helpers for the string literal unescaper.
// Depends on nothing; used by every other design file but slu_if.
package slu_pkg;

  localparam int MaxLenDef = 256;
  localparam int OutDepth  = 4;
  localparam int OutPtrW   = $clog2(OutDepth);
  localparam int OutCntW   = $clog2(OutDepth + 1);

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindEnd  = 2'd1;
  localparam logic [1:0] KindMiss = 2'd2;

  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChLowT  = 8'h74;
  localparam logic [7:0] ChLowN  = 8'h6E;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChLowR  = 8'h72;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeEsc    = 2'd1,
    ModeOct    = 2'd2,
    ModeQuote  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [8:0] length;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } esc_t;

  function automatic esc_t esc_map(logic [7:0] ch);
    esc_t e;
    e.hit   = 1'b1;
    e.value = ch;
    case (ch)
      ChLowB:  e.value = ChBs;
      ChLowT:  e.value = ChTab;
      ChLowN:  e.value = ChLf;
      ChLowF:  e.value = ChFf;
      ChLowR:  e.value = ChCr;
      ChDq:    e.value = ChDq;
      ChSq:    e.value = ChSq;
      ChBsl:   e.value = ChBsl;
      default: e.hit   = 1'b0;
    endcase
    return e;
  endfunction

  function automatic logic is_octal(logic [7:0] ch);
    return ch[7:3] == 5'b00110;
  endfunction

endpackage

@@ design/slu_if.sv @@
// Valid/ready channel interfaces for raw input bytes and decoded results.
// Depends on nothing.
interface slu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface slu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [8:0] length;
  logic       last;

  modport source (output valid, output kind, output data_byte, output length,
                  output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input length,
                  input last, output ready);
endinterface

@@ design/string_literal_unescaper_unit.sv @@
// String literal unescaper: decodes the body of a double-quoted literal.
// One raw byte per word on in_i; decoded bytes and end markers on out_o.
// Input words carry ch, the next byte after the opening quote. Each input word
// yields zero, one or two result words (kind, data_byte, length, last); last
// marks the final result of that input word. Kind 1 ends the string normally,
// kind 2 reports a carriage return before the closing quote; either end
// returns the decoder to its start state for the next literal.
// Throughput: one input word per cycle while the queue has room and results
// drain at one per cycle. Results are registered in the queue before they
// appear on out_o.
// The decoder state updates in the same cycle the word is taken; results sit in
// a four-word queue, and in_i.ready stays high while the queue has two free
// entries, so a stalled receiver blocks in_i once three or more words wait.
// Reset clears the decoder to plain-text mode with a zero length and empties
// the queue; no words are lost or repeated under any stall pattern.
// length saturates at MaxLen and is reported in 9 bits.
module string_literal_unescaper_unit #(
  parameter int MaxLen = slu_pkg::MaxLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slu_in_if.sink     in_i,
  slu_out_if.source  out_o
);

  slu_pkg::res_pair_t pair;
  slu_pkg::res_t      res;
  logic               accept;
  logic               space;

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;

  slu_decode #(
    .MaxLen (MaxLen)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .ch_i   (in_i.ch),
    .pair_o (pair)
  );

  slu_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .pair_i  (pair),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.kind      = res.kind;
  assign out_o.data_byte = res.data_byte;
  assign out_o.length    = res.length;
  assign out_o.last      = res.last;

endmodule

@@ design/slu_decode.sv @@
// Escape decoder: mode, octal and length state plus up to two results per byte.
// Depends on slu_pkg.
module slu_decode #(
  parameter int MaxLen = slu_pkg::MaxLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [7:0]          ch_i,
  output slu_pkg::res_pair_t  pair_o
);

  localparam int CntW = $clog2(MaxLen + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxLen);

  slu_pkg::mode_e  mode_q, mode_d;
  logic [7:0]      oct_val_q, oct_val_d;
  logic [1:0]      oct_dig_q, oct_dig_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic slu_pkg::res_t mk(logic [1:0] k, logic [7:0] d, logic [CntW-1:0] c);
    slu_pkg::res_t   r;
    logic [CntW+8:0] e;
    e           = {9'd0, c};
    r.kind      = k;
    r.data_byte = d;
    r.length    = e[8:0];
    r.last      = 1'b0;
    return r;
  endfunction

  always_comb begin
    slu_pkg::res_pair_t p;
    slu_pkg::res_t      r;
    slu_pkg::esc_t      e;
    logic               do_plain;
    logic [7:0]         nv;
    p         = '0;
    r         = '0;
    do_plain  = 1'b0;
    mode_d    = mode_q;
    oct_val_d = oct_val_q;
    oct_dig_d = oct_dig_q;
    cnt_d     = cnt_q;
    e         = slu_pkg::esc_map(ch_i);
    nv        = {oct_val_q[4:0], ch_i[2:0]};

    case (mode_q)
      slu_pkg::ModeEsc: begin
        mode_d = slu_pkg::ModeNormal;
        if (e.hit) begin
          if (cnt_d != CntMax) cnt_d = cnt_d + 1'b1;
          p.r0  = mk(slu_pkg::KindData, e.value, cnt_d);
          p.num = 2'd1;
        end else if (slu_pkg::is_octal(ch_i)) begin
          mode_d    = slu_pkg::ModeOct;
          oct_val_d = {5'd0, ch_i[2:0]};
          oct_dig_d = 2'd1;
        end else begin
          if (cnt_d != CntMax) cnt_d = cnt_d + 1'b1;
          p.r0     = mk(slu_pkg::KindData, slu_pkg::ChBsl, cnt_d);
          p.num    = 2'd1;
          do_plain = 1'b1;
        end
      end
      slu_pkg::ModeOct: begin
        if (slu_pkg::is_octal(ch_i)) begin
          if (oct_dig_q == 2'd2) begin
            mode_d    = slu_pkg::ModeNormal;
            oct_val_d = '0;
            oct_dig_d = '0;
            if (cnt_d != CntMax) cnt_d = cnt_d + 1'b1;
            p.r0  = mk(slu_pkg::KindData, nv, cnt_d);
            p.num = 2'd1;
          end else begin
            oct_val_d = nv;
            oct_dig_d = oct_dig_q + 2'd1;
          end
        end else begin
          mode_d    = slu_pkg::ModeNormal;
          oct_val_d = '0;
          oct_dig_d = '0;
          if (cnt_d != CntMax) cnt_d = cnt_d + 1'b1;
          p.r0     = mk(slu_pkg::KindData, oct_val_q, cnt_d);
          p.num    = 2'd1;
          do_plain = 1'b1;
        end
      end
      slu_pkg::ModeQuote: begin
        if (ch_i == slu_pkg::ChDq) begin
          mode_d = slu_pkg::ModeNormal;
          if (cnt_d != CntMax) cnt_d = cnt_d + 1'b1;
          p.r0  = mk(slu_pkg::KindData, slu_pkg::ChDq, cnt_d);
          p.num = 2'd1;
        end else begin
          p.r0      = mk(slu_pkg::KindEnd, 8'd0, cnt_d);
          p.num     = 2'd1;
          mode_d    = slu_pkg::ModeNormal;
          oct_val_d = '0;
          oct_dig_d = '0;
          cnt_d     = '0;
        end
      end
      default: do_plain = 1'b1;
    endcase

    if (do_plain) begin
      r = '0;
      if (ch_i == slu_pkg::ChCr) begin
        r         = mk(slu_pkg::KindMiss, 8'd0, cnt_d);
        mode_d    = slu_pkg::ModeNormal;
        oct_val_d = '0;
        oct_dig_d = '0;
        cnt_d     = '0;
      end else if (ch_i == slu_pkg::ChDq) begin
        mode_d = slu_pkg::ModeQuote;
      end else if (ch_i == slu_pkg::ChBsl) begin
        mode_d = slu_pkg::ModeEsc;
      end else begin
        if (cnt_d != CntMax) cnt_d = cnt_d + 1'b1;
        r = mk(slu_pkg::KindData, ch_i, cnt_d);
      end
      if (ch_i != slu_pkg::ChDq && ch_i != slu_pkg::ChBsl) begin
        if (p.num == 2'd0) p.r0 = r;
        else               p.r1 = r;
        p.num = p.num + 2'd1;
      end
    end

    if (p.num == 2'd1) p.r0.last = 1'b1;
    if (p.num == 2'd2) p.r1.last = 1'b1;
    pair_o = p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= slu_pkg::ModeNormal;
      oct_val_q <= '0;
      oct_dig_q <= '0;
      cnt_q     <= '0;
    end else if (en_i) begin
      mode_q    <= mode_d;
      oct_val_q <= oct_val_d;
      oct_dig_q <= oct_dig_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

@@ design/slu_out_fifo.sv @@
// Result queue: takes zero to two words per cycle, hands out one word per cycle while ready_i is high.
// Depends on slu_pkg.
module slu_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  slu_pkg::res_pair_t  pair_i,
  output logic                space_o,
  output logic                valid_o,
  input  logic                ready_i,
  output slu_pkg::res_t       res_o
);

  localparam int PtrW = slu_pkg::OutPtrW;
  localparam int CntW = slu_pkg::OutCntW;

  slu_pkg::res_t       mem_q [slu_pkg::OutDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [1:0]          num;
  logic                pop;

  assign num     = push_i ? pair_i.num : 2'd0;
  assign pop     = valid_o && ready_i;
  assign valid_o = cnt_q != '0;
  assign space_o = cnt_q <= CntW'(slu_pkg::OutDepth - 2);
  assign res_o   = mem_q[rd_ptr_q];
  assign wr_ptr_d = wr_ptr_q + PtrW'(num);
  assign cnt_d    = cnt_q + CntW'(num) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (num != 2'd0) mem_q[wr_ptr_q] <= pair_i.r0;
    if (num == 2'd2) mem_q[wr_ptr_q + PtrW'(1)] <= pair_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(slu_pkg::OutDepth))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (num != 2'd0) |-> space_o)
    else $error("result queue written without room");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && num == 2'd0) |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("result queue count did not drop on pop");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("result queue pointers disagree when empty");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Testbench for string_literal_unescaper_unit: feeds raw literal bytes with random gaps,
// stalls the result side, predicts every decoded word and checks them in order.
// Depends on slu_pkg, the slu_in_if/slu_out_if channels and the unit itself.
module tb;

  localparam int MaxLen = slu_pkg::MaxLenDef;

  class slu_scoreboard;
    slu_pkg::res_t  decoded_q[$];
    slu_pkg::mode_e mode;
    logic [7:0]     oct_val;
    int unsigned    oct_digits;
    int unsigned    byte_count;
    int unsigned    errors;
    int unsigned    words;
    int unsigned    raw_bytes;
    int unsigned    closed;
    int unsigned    missing;
    int unsigned    capped;

    function void restart();
      mode       = slu_pkg::ModeNormal;
      oct_val    = '0;
      oct_digits = 0;
      byte_count = 0;
    endfunction

    function void push_word(logic [1:0] kind, logic [7:0] value);
      slu_pkg::res_t w;
      w.kind      = kind;
      w.data_byte = value;
      w.length    = byte_count[8:0];
      w.last      = 1'b0;
      decoded_q.push_back(w);
    endfunction

    function void push_byte(logic [7:0] value);
      if (byte_count < MaxLen) byte_count++;
      push_word(slu_pkg::KindData, value);
    endfunction

    function void plain_char(logic [7:0] ch);
      if (ch == slu_pkg::ChCr) begin
        push_word(slu_pkg::KindMiss, '0);
        restart();
      end else if (ch == slu_pkg::ChDq) begin
        mode = slu_pkg::ModeQuote;
      end else if (ch == slu_pkg::ChBsl) begin
        mode = slu_pkg::ModeEsc;
      end else begin
        push_byte(ch);
      end
    endfunction

    function void take_raw_byte(logic [7:0] ch);
      int unsigned   n_prior;
      slu_pkg::res_t w;
      n_prior = decoded_q.size();
      raw_bytes++;
      case (mode)
        slu_pkg::ModeEsc: begin
          mode = slu_pkg::ModeNormal;
          case (ch)
            slu_pkg::ChLowB: push_byte(slu_pkg::ChBs);
            slu_pkg::ChLowT: push_byte(slu_pkg::ChTab);
            slu_pkg::ChLowN: push_byte(slu_pkg::ChLf);
            slu_pkg::ChLowF: push_byte(slu_pkg::ChFf);
            slu_pkg::ChLowR: push_byte(slu_pkg::ChCr);
            slu_pkg::ChDq, slu_pkg::ChSq, slu_pkg::ChBsl: push_byte(ch);
            default: begin
              if (ch >= 8'h30 && ch <= 8'h37) begin
                mode       = slu_pkg::ModeOct;
                oct_val    = {5'b0, ch[2:0]};
                oct_digits = 1;
              end else begin
                push_byte(slu_pkg::ChBsl);
                plain_char(ch);
              end
            end
          endcase
        end
        slu_pkg::ModeOct: begin
          if (ch >= 8'h30 && ch <= 8'h37) begin
            oct_val = {oct_val[4:0], ch[2:0]};
            oct_digits++;
            if (oct_digits == 3) begin
              mode = slu_pkg::ModeNormal;
              push_byte(oct_val);
              oct_val    = '0;
              oct_digits = 0;
            end
          end else begin
            mode = slu_pkg::ModeNormal;
            push_byte(oct_val);
            oct_val    = '0;
            oct_digits = 0;
            plain_char(ch);
          end
        end
        slu_pkg::ModeQuote: begin
          if (ch == slu_pkg::ChDq) begin
            mode = slu_pkg::ModeNormal;
            push_byte(slu_pkg::ChDq);
          end else begin
            push_word(slu_pkg::KindEnd, '0);
            restart();
          end
        end
        default: plain_char(ch);
      endcase
      if (decoded_q.size() > n_prior) begin
        w      = decoded_q.pop_back();
        w.last = 1'b1;
        decoded_q.push_back(w);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_decoded(slu_pkg::res_t got);
      slu_pkg::res_t want;
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected word kind=%0d data=%02h length=%0d last=%0d",
                         got.kind, got.data_byte, got.length, got.last));
      end else begin
        want = decoded_q.pop_front();
        words++;
        if (got.kind != want.kind)
          report($sformatf("word %0d kind %0d, want %0d", words, got.kind, want.kind));
        if (got.data_byte != want.data_byte)
          report($sformatf("word %0d data %02h, want %02h", words, got.data_byte,
                           want.data_byte));
        if (got.length != want.length)
          report($sformatf("word %0d length %0d, want %0d", words, got.length, want.length));
        if (got.last != want.last)
          report($sformatf("word %0d last %0d, want %0d", words, got.last, want.last));
        if (want.kind == slu_pkg::KindEnd) closed++;
        if (want.kind == slu_pkg::KindMiss) missing++;
        if (want.kind == slu_pkg::KindData && want.length == MaxLen) capped++;
      end
    endtask
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          hold_off;
  int unsigned   sent;
  slu_scoreboard sb;

  slu_in_if  raw_bus ();
  slu_out_if dec_bus ();

  string_literal_unescaper_unit #(
    .MaxLen(MaxLen)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (raw_bus),
    .out_o (dec_bus)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic send_raw(input logic [7:0] ch);
    int unsigned gap;
    gap = $urandom_range(0, 5);
    if (sent >= 300 && sent < 360) gap = 0;
    if (gap != 0) begin
      raw_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    raw_bus.valid <= 1'b1;
    raw_bus.ch    <= ch;
    do @(posedge clk_i); while (!raw_bus.ready);
    sb.take_raw_byte(ch);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic is_escape_letter(logic [7:0] ch);
    case (ch)
      slu_pkg::ChLowB, slu_pkg::ChLowT, slu_pkg::ChLowN, slu_pkg::ChLowF,
      slu_pkg::ChLowR, slu_pkg::ChDq, slu_pkg::ChSq, slu_pkg::ChBsl: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == slu_pkg::ChCr || b == slu_pkg::ChDq || b == slu_pkg::ChBsl);
    return b;
  endfunction

  function automatic logic [7:0] pick_escape_letter();
    case ($urandom_range(0, 7))
      0: return slu_pkg::ChLowB;
      1: return slu_pkg::ChLowT;
      2: return slu_pkg::ChLowN;
      3: return slu_pkg::ChLowF;
      4: return slu_pkg::ChLowR;
      5: return slu_pkg::ChDq;
      6: return slu_pkg::ChSq;
      default: return slu_pkg::ChBsl;
    endcase
  endfunction

  function automatic logic [7:0] pick_unknown_escape();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (is_escape_letter(b) || (b >= 8'h30 && b <= 8'h37));
    return b;
  endfunction

  task automatic send_element();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send_raw(pick_plain());
    end else if (r < 62) begin
      send_raw(slu_pkg::ChBsl);
      send_raw(pick_escape_letter());
    end else if (r < 74) begin
      send_raw(slu_pkg::ChBsl);
      n = $urandom_range(1, 3);
      repeat (n) send_raw(8'h30 + 8'($urandom_range(0, 7)));
    end else if (r < 82) begin
      send_raw(slu_pkg::ChDq);
      send_raw(slu_pkg::ChDq);
    end else if (r < 92) begin
      send_raw(slu_pkg::ChBsl);
      send_raw(pick_unknown_escape());
    end else begin
      send_raw(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_ending();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      send_raw(slu_pkg::ChCr);
    end else begin
      send_raw(slu_pkg::ChDq);
      b = 8'($urandom_range(0, 255));
      if (b == slu_pkg::ChDq) b = 8'h20;
      send_raw(b);
    end
  endtask

  // hold off the result side long enough for the output queue to fill
  initial begin
    hold_off = 1'b0;
    wait (sent >= 150);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (120) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    int unsigned   stall;
    slu_pkg::res_t got;
    dec_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 5);
      if (sb.words >= 300 && sb.words < 360) stall = 0;
      if (stall != 0 || hold_off) begin
        dec_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
        while (hold_off) @(negedge clk_i);
      end
      dec_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!dec_bus.valid);
      got.kind      = dec_bus.kind;
      got.data_byte = dec_bus.data_byte;
      got.length    = dec_bus.length;
      got.last      = dec_bus.last;
      sb.check_decoded(got);
      @(negedge clk_i);
    end
  end

  initial begin
    logic [7:0] directed_q[$];
    sb = new();
    sb.restart();
    raw_bus.valid = 1'b0;
    raw_bus.ch    = '0;
    rst_ni        = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_q = {8'h00, 8'hFF, slu_pkg::ChBsl, slu_pkg::ChLowN,
                  slu_pkg::ChBsl, slu_pkg::ChDq,
                  slu_pkg::ChBsl, 8'h31, 8'h32, 8'h33,
                  slu_pkg::ChBsl, 8'h37, 8'h78,
                  slu_pkg::ChBsl, 8'h71,
                  slu_pkg::ChBsl, 8'h37, 8'h37, 8'h37,
                  slu_pkg::ChDq, slu_pkg::ChDq, slu_pkg::ChDq, 8'h41,
                  slu_pkg::ChBsl, slu_pkg::ChCr, slu_pkg::ChCr};
    foreach (directed_q[i]) send_raw(directed_q[i]);

    // one literal long enough to run the length into its cap
    repeat (262) send_raw(pick_plain());
    repeat (6) send_element();
    send_ending();

    while (sent < 520) begin
      repeat ($urandom_range(0, 12)) send_element();
      send_ending();
    end
    raw_bus.valid <= 1'b0;

    while (sb.decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d raw bytes, checked %0d decoded words.", sb.raw_bytes, sb.words);
    $display("Strings closed %0d, missing quotes %0d, words at the length cap %0d.",
             sb.closed, sb.missing, sb.capped);
    if (sb.errors == 0) begin
      $display("string_literal_unescaper_unit test passed");
    end else begin
      $display("string_literal_unescaper_unit test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d words still expected", sb.decoded_q.size());
    $display("string_literal_unescaper_unit test failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/slu_pkg.sv
design/slu_if.sv
design/slu_decode.sv
design/slu_out_fifo.sv
design/string_literal_unescaper_unit.sv
tb/tb.sv
